// ----- sv/rcbt_pkg.sv -----
// Shared constants, action codes and control structs of the block buffer table.
`default_nettype none
package rcbt_pkg;

    // Fixed field widths of the request and result items.
    localparam int OP_W    = 3;
    localparam int BNO_W   = 16;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 3;
    localparam int REFS_W  = 8;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEF    = 16;
    localparam int BLOCK_BITS_DEF = 16;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_GET     = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_W-1:0] OP_DIRTY   = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE    = 3'd3;
    localparam logic [OP_W-1:0] OP_SYNC    = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNDER = 3'd3;
    localparam logic [STAT_W-1:0] ST_WB    = 3'd4;
    localparam logic [STAT_W-1:0] ST_DONE  = 3'd5;
    localparam logic [STAT_W-1:0] ST_OVER  = 3'd6;

    // Largest reference count.
    localparam logic [REFS_W-1:0] REFS_MAX = 8'hFF;

    // Datapath actions issued by the controller.
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] A_NONE      = 4'd0;
    localparam logic [ACT_W-1:0] A_LOAD      = 4'd1;
    localparam logic [ACT_W-1:0] A_READ_PTR  = 4'd2;
    localparam logic [ACT_W-1:0] A_READ_IDX  = 4'd3;
    localparam logic [ACT_W-1:0] A_SCAN_NEXT = 4'd4;
    localparam logic [ACT_W-1:0] A_HIT       = 4'd5;
    localparam logic [ACT_W-1:0] A_MISS      = 4'd6;
    localparam logic [ACT_W-1:0] A_RELEASE   = 4'd7;
    localparam logic [ACT_W-1:0] A_REJECT    = 4'd8;
    localparam logic [ACT_W-1:0] A_DIRTY     = 4'd9;
    localparam logic [ACT_W-1:0] A_FREE      = 4'd10;
    localparam logic [ACT_W-1:0] A_SYNC_WB   = 4'd11;
    localparam logic [ACT_W-1:0] A_DONE      = 4'd12;

    typedef struct packed {
        logic [ACT_W-1:0] act;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_ok;
        logic            idx_live;
        logic            hit;
        logic            ptr_last;
        logic            sync_sel;
        logic            out_free;
    } t_stat;

endpackage
`default_nettype wire

// ----- sv/rcbt_in_if.sv -----
// Request channel of the block buffer table.
`default_nettype none
interface rcbt_in_if;
    logic                        valid;
    logic                        ready;
    logic [rcbt_pkg::OP_W-1:0]   opcode;
    logic [rcbt_pkg::BNO_W-1:0]  block_number;
    logic [rcbt_pkg::IDX_W-1:0]  entry_index;

    modport source (output valid, output opcode, output block_number,
                    output entry_index, input ready);
    modport sink   (input valid, input opcode, input block_number,
                    input entry_index, output ready);
endinterface
`default_nettype wire

// ----- sv/rcbt_out_if.sv -----
// Result channel of the block buffer table.
`default_nettype none
interface rcbt_out_if;
    logic                        valid;
    logic                        ready;
    logic [rcbt_pkg::STAT_W-1:0] status;
    logic [rcbt_pkg::IDX_W-1:0]  entry_index_out;
    logic [rcbt_pkg::BNO_W-1:0]  block_number_out;
    logic                        last;

    modport source (output valid, output status, output entry_index_out,
                    output block_number_out, output last, input ready);
    modport sink   (input valid, input status, input entry_index_out,
                    input block_number_out, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/refcounted_block_buffer_table_core.sv -----
// Top level of the reference counted block buffer table.
// A get scans the entries in order, reading one entry of the block store at a time and
// comparing its block number; release reads the indexed entry before it writes it back.
// Sync scans the whole table; one request is in work at a time.
// Synchronous active-low reset clears the used, dirty and nonzero-count flags;
// the block store itself is not cleared and needs no clearing pass.
`default_nettype none
module refcounted_block_buffer_table_core #(
    parameter int ENTRIES    = rcbt_pkg::ENTRIES_DEF,
    parameter int BLOCK_BITS = rcbt_pkg::BLOCK_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rcbt_in_if.sink     i_in,
    rcbt_out_if.source  o_out
);

    // The controller only talks to the datapath through these two structs.
    rcbt_pkg::t_cmd  cmd;
    rcbt_pkg::t_stat stat;
    logic            in_ready;

    // The controller owns the request handshake: it takes a new item only when the
    // previous one has put all of its results into the output register. A result may
    // still be waiting there while the next item is accepted and starts its scan.
    rcbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the entry store, the per-entry flags and the result register
    // that drives the result channel.
    rcbt_datapath #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_opcode           (i_in.opcode),
        .i_block_number     (i_in.block_number),
        .i_entry_index      (i_in.entry_index),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_status           (o_out.status),
        .o_entry_index_out  (o_out.entry_index_out),
        .o_block_number_out (o_out.block_number_out),
        .o_last             (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule
`default_nettype wire

// ----- sv/rcbt_ctrl.sv -----
// Sequencing state machine of the block buffer table.
`default_nettype none
module rcbt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rcbt_pkg::t_stat i_stat,
    output rcbt_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_GET_RD   = 4'd2;
    localparam logic [3:0] S_GET_CMP  = 4'd3;
    localparam logic [3:0] S_GET_HIT  = 4'd4;
    localparam logic [3:0] S_GET_MISS = 4'd5;
    localparam logic [3:0] S_REL_RD   = 4'd6;
    localparam logic [3:0] S_REL_WR   = 4'd7;
    localparam logic [3:0] S_REJECT   = 4'd8;
    localparam logic [3:0] S_DIRTY    = 4'd9;
    localparam logic [3:0] S_FREE     = 4'd10;
    localparam logic [3:0] S_SYNC_CHK = 4'd11;
    localparam logic [3:0] S_SYNC_WB  = 4'd12;
    localparam logic [3:0] S_SYNC_END = 4'd13;
    localparam logic [3:0] S_UNKNOWN  = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       cmd_emits;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        o_cmd.act = rcbt_pkg::A_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.act = rcbt_pkg::A_LOAD;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.op)
                    rcbt_pkg::OP_GET:     n_state = S_GET_RD;
                    rcbt_pkg::OP_RELEASE: n_state = i_stat.idx_live ? S_REL_RD : S_REJECT;
                    rcbt_pkg::OP_DIRTY:   n_state = S_DIRTY;
                    rcbt_pkg::OP_FREE:    n_state = S_FREE;
                    rcbt_pkg::OP_SYNC:    n_state = S_SYNC_CHK;
                    default:              n_state = S_UNKNOWN;
                endcase
            end
            S_GET_RD: begin
                o_cmd.act = rcbt_pkg::A_READ_PTR;
                n_state   = S_GET_CMP;
            end
            S_GET_CMP: begin
                if (i_stat.hit) begin
                    n_state = S_GET_HIT;
                end else begin
                    o_cmd.act = rcbt_pkg::A_SCAN_NEXT;
                    n_state   = i_stat.ptr_last ? S_GET_MISS : S_GET_RD;
                end
            end
            S_GET_HIT: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_HIT;
                    n_state   = S_IDLE;
                end
            end
            S_GET_MISS: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_MISS;
                    n_state   = S_IDLE;
                end
            end
            S_REL_RD: begin
                o_cmd.act = rcbt_pkg::A_READ_IDX;
                n_state   = S_REL_WR;
            end
            S_REL_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_RELEASE;
                    n_state   = S_IDLE;
                end
            end
            S_REJECT: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_REJECT;
                    n_state   = S_IDLE;
                end
            end
            S_DIRTY: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_DIRTY;
                    n_state   = S_IDLE;
                end
            end
            S_FREE: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_FREE;
                    n_state   = S_IDLE;
                end
            end
            S_SYNC_CHK: begin
                if (i_stat.sync_sel) begin
                    o_cmd.act = rcbt_pkg::A_READ_PTR;
                    n_state   = S_SYNC_WB;
                end else begin
                    o_cmd.act = rcbt_pkg::A_SCAN_NEXT;
                    n_state   = i_stat.ptr_last ? S_SYNC_END : S_SYNC_CHK;
                end
            end
            S_SYNC_WB: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_SYNC_WB;
                    n_state   = i_stat.ptr_last ? S_SYNC_END : S_SYNC_CHK;
                end
            end
            S_SYNC_END, S_UNKNOWN: begin
                if (i_stat.out_free) begin
                    o_cmd.act = rcbt_pkg::A_DONE;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign cmd_emits = (o_cmd.act == rcbt_pkg::A_HIT)     || (o_cmd.act == rcbt_pkg::A_MISS)
                    || (o_cmd.act == rcbt_pkg::A_RELEASE) || (o_cmd.act == rcbt_pkg::A_REJECT)
                    || (o_cmd.act == rcbt_pkg::A_DIRTY)   || (o_cmd.act == rcbt_pkg::A_FREE)
                    || (o_cmd.act == rcbt_pkg::A_SYNC_WB) || (o_cmd.act == rcbt_pkg::A_DONE);

    // An accepted request is always decoded in the following cycle.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISPATCH))
        else $error("accepted request not dispatched");

    // A result is only produced when the output register can take it.
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_emits |-> i_stat.out_free)
        else $error("result issued into a full output register");

    // A writeback during a sync is never the final result of the request.
    a_sync_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.act == rcbt_pkg::A_SYNC_WB) |=> (r_state != S_IDLE))
        else $error("sync ended without its closing result");

endmodule
`default_nettype wire

// ----- sv/rcbt_datapath.sv -----
// Entry store, flag vectors, scan pointer and result register of the block buffer table.
`default_nettype none
module rcbt_datapath #(
    parameter int ENTRIES    = rcbt_pkg::ENTRIES_DEF,
    parameter int BLOCK_BITS = rcbt_pkg::BLOCK_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rcbt_pkg::t_cmd                i_cmd,
    output rcbt_pkg::t_stat                    o_stat,
    input  wire logic [rcbt_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [rcbt_pkg::BNO_W-1:0]    i_block_number,
    input  wire logic [rcbt_pkg::IDX_W-1:0]    i_entry_index,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [rcbt_pkg::STAT_W-1:0]        o_status,
    output logic [rcbt_pkg::IDX_W-1:0]         o_entry_index_out,
    output logic [rcbt_pkg::BNO_W-1:0]         o_block_number_out,
    output logic                               o_last
);

    localparam int IW = $clog2(ENTRIES);
    localparam int BW = (BLOCK_BITS < rcbt_pkg::BNO_W) ? BLOCK_BITS : rcbt_pkg::BNO_W;
    localparam int RW = rcbt_pkg::REFS_W;
    localparam int WW = RW + BW;

    // Request registers.
    logic [rcbt_pkg::OP_W-1:0]  r_op;
    logic [BW-1:0]              r_bno;
    logic [rcbt_pkg::IDX_W-1:0] r_idx;

    // Scan pointer and first free entry seen.
    logic [IW-1:0] r_ptr, n_ptr;
    logic          r_free_found, n_free_found;
    logic [IW-1:0] r_free_idx, n_free_idx;

    // Per-entry flags; a nonzero count implies a used entry.
    logic [ENTRIES-1:0] r_used, n_used;
    logic [ENTRIES-1:0] r_dirty, n_dirty;
    logic [ENTRIES-1:0] r_refnz, n_refnz;

    // Count and block number per entry.
    logic [WW-1:0] r_mem [ENTRIES];
    logic [WW-1:0] r_rd_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    // Result register.
    logic                        r_out_valid;
    logic [rcbt_pkg::STAT_W-1:0] r_status;
    logic [rcbt_pkg::IDX_W-1:0]  r_idx_out;
    logic [rcbt_pkg::BNO_W-1:0]  r_bno_out;
    logic                        r_last;

    logic                        emit;
    logic [rcbt_pkg::STAT_W-1:0] e_status;
    logic [rcbt_pkg::IDX_W-1:0]  e_idx;
    logic [rcbt_pkg::BNO_W-1:0]  e_blk;
    logic                        e_last;

    logic [31:0]    idx_wide;
    logic [31:0]    ptr_wide;
    logic [31:0]    free_wide;
    logic [IW-1:0]  idx_addr;
    logic           idx_ok;
    logic [RW-1:0]  rd_refs;
    logic [BW-1:0]  rd_blk;
    logic [RW-1:0]  rel_refs;
    logic           out_free;

    assign idx_wide  = 32'(r_idx);
    assign ptr_wide  = 32'(r_ptr);
    assign free_wide = 32'(r_free_idx);
    assign idx_addr  = idx_wide[IW-1:0];
    assign idx_ok    = (idx_wide < 32'(ENTRIES));
    assign rd_refs   = r_rd_data[WW-1:BW];
    assign rd_blk    = r_rd_data[BW-1:0];
    assign rel_refs  = rd_refs - 1'b1;
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.op       = r_op;
    assign o_stat.idx_ok   = idx_ok;
    assign o_stat.idx_live = idx_ok && r_refnz[idx_addr];
    assign o_stat.hit      = r_used[r_ptr] && (rd_blk == r_bno);
    assign o_stat.ptr_last = (r_ptr == IW'(ENTRIES - 1));
    assign o_stat.sync_sel = r_dirty[r_ptr] && r_refnz[r_ptr];
    assign o_stat.out_free = out_free;

    assign rd_en   = (i_cmd.act == rcbt_pkg::A_READ_PTR) || (i_cmd.act == rcbt_pkg::A_READ_IDX);
    assign rd_addr = (i_cmd.act == rcbt_pkg::A_READ_IDX) ? idx_addr : r_ptr;

    always_comb begin
        n_used       = r_used;
        n_dirty      = r_dirty;
        n_refnz      = r_refnz;
        n_ptr        = r_ptr;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        we           = 1'b0;
        wr_addr      = r_ptr;
        wr_data      = r_rd_data;
        emit         = 1'b0;
        e_status     = rcbt_pkg::ST_DONE;
        e_idx        = '0;
        e_blk        = '0;
        e_last       = 1'b1;
        case (i_cmd.act)
            rcbt_pkg::A_LOAD: begin
                n_ptr        = '0;
                n_free_found = 1'b0;
            end
            rcbt_pkg::A_SCAN_NEXT: begin
                if (!r_used[r_ptr] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_ptr;
                end
                n_ptr = r_ptr + 1'b1;
            end
            rcbt_pkg::A_HIT: begin
                emit  = 1'b1;
                e_idx = ptr_wide[rcbt_pkg::IDX_W-1:0];
                if (rd_refs == rcbt_pkg::REFS_MAX) begin
                    e_status = rcbt_pkg::ST_OVER;
                end else begin
                    e_status       = rcbt_pkg::ST_HIT;
                    we             = 1'b1;
                    wr_data        = {rd_refs + 1'b1, rd_blk};
                    n_refnz[r_ptr] = 1'b1;
                end
            end
            rcbt_pkg::A_MISS: begin
                emit = 1'b1;
                if (r_free_found) begin
                    e_status            = rcbt_pkg::ST_MISS;
                    e_idx               = free_wide[rcbt_pkg::IDX_W-1:0];
                    e_blk               = rcbt_pkg::BNO_W'(r_bno);
                    we                  = 1'b1;
                    wr_addr             = r_free_idx;
                    wr_data             = {RW'(1), r_bno};
                    n_used[r_free_idx]  = 1'b1;
                    n_dirty[r_free_idx] = 1'b0;
                    n_refnz[r_free_idx] = 1'b1;
                end else begin
                    e_status = rcbt_pkg::ST_FULL;
                end
            end
            rcbt_pkg::A_RELEASE: begin
                emit              = 1'b1;
                e_idx             = r_idx;
                we                = 1'b1;
                wr_addr           = idx_addr;
                wr_data           = {rel_refs, rd_blk};
                n_refnz[idx_addr] = (rel_refs != '0);
                if ((rel_refs == '0) && r_dirty[idx_addr]) begin
                    e_status = rcbt_pkg::ST_WB;
                    e_blk    = rcbt_pkg::BNO_W'(rd_blk);
                end
            end
            rcbt_pkg::A_REJECT: begin
                emit     = 1'b1;
                e_idx    = r_idx;
                e_status = idx_ok ? rcbt_pkg::ST_UNDER : rcbt_pkg::ST_DONE;
            end
            rcbt_pkg::A_DIRTY: begin
                emit  = 1'b1;
                e_idx = r_idx;
                if (idx_ok && r_used[idx_addr]) begin
                    n_dirty[idx_addr] = 1'b1;
                end
            end
            rcbt_pkg::A_FREE: begin
                emit    = 1'b1;
                n_used  = r_used & r_refnz;
                n_dirty = r_dirty & r_refnz;
            end
            rcbt_pkg::A_SYNC_WB: begin
                emit           = 1'b1;
                e_status       = rcbt_pkg::ST_WB;
                e_idx          = ptr_wide[rcbt_pkg::IDX_W-1:0];
                e_blk          = rcbt_pkg::BNO_W'(rd_blk);
                e_last         = 1'b0;
                n_dirty[r_ptr] = 1'b0;
                n_ptr          = r_ptr + 1'b1;
            end
            rcbt_pkg::A_DONE: begin
                emit = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == rcbt_pkg::A_LOAD) begin
            r_op  <= i_opcode;
            r_bno <= i_block_number[BW-1:0];
            r_idx <= i_entry_index;
        end
        r_ptr      <= n_ptr;
        r_free_idx <= n_free_idx;
        if (emit) begin
            r_status  <= e_status;
            r_idx_out <= e_idx;
            r_bno_out <= e_blk;
            r_last    <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_dirty      <= '0;
            r_refnz      <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used       <= n_used;
            r_dirty      <= n_dirty;
            r_refnz      <= n_refnz;
            r_free_found <= n_free_found;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_entry_index_out  = r_idx_out;
    assign o_block_number_out = r_bno_out;
    assign o_last             = r_last;

    // Only a used entry may be dirty.
    a_dirty_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty & ~r_used) == '0)
        else $error("dirty flag on an unused entry");

    // Only a used entry may hold references.
    a_refs_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_refnz & ~r_used) == '0)
        else $error("reference count on an unused entry");

    // The scan pointer stays inside the table while it still steps.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.act == rcbt_pkg::A_SCAN_NEXT) || (i_cmd.act == rcbt_pkg::A_SYNC_WB))
        |-> (ptr_wide < 32'(ENTRIES)))
        else $error("scan pointer beyond the table");

endmodule
`default_nettype wire
